@@ rtl/swpa_pkg.sv @@
`default_nettype none
package swpa_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 256;
  localparam int unsigned DEF_MAX_HEIGHT = 256;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned PIX_W      = 24;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned SUM_W      = 24;
  localparam int unsigned CNT_W      = 16;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH       = 3'd0,
    REG_IMAGE_HEIGHT      = 3'd1,
    REG_WINDOW_SIZE       = 3'd2,
    REG_SCAN_DIRECTION    = 3'd3,
    REG_SAMPLES_PER_PIXEL = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIR_ROW    = 2'd0,
    DIR_RANDOM = 2'd1,
    DIR_COL    = 2'd2
  } scan_dir_t;

  typedef enum logic [1:0] {
    MOVE_RIGHT = 2'd0,
    MOVE_DOWN  = 2'd1,
    MOVE_LEFT  = 2'd2,
    MOVE_UP    = 2'd3
  } move_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_READ,
    ST_DRAIN,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [CH_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

@@ rtl/swpa_if.sv @@
`default_nettype none
interface swpa_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] write_x;
  logic [7:0] write_y;
  logic [7:0] write_red;
  logic [7:0] write_green;
  logic [7:0] write_blue;
  logic [1:0] random_move;

  modport source (output valid, mode, write_x, write_y, write_red, write_green, write_blue,
                  random_move, input ready);
  modport sink (input valid, mode, write_x, write_y, write_red, write_green, write_blue,
                random_move, output ready);
endinterface

interface swpa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] avg_red;
  logic [7:0] avg_green;
  logic [7:0] avg_blue;
  logic [7:0] centre_x;
  logic [7:0] centre_y;
  logic       advanced;

  modport source (output valid, avg_red, avg_green, avg_blue, centre_x, centre_y, advanced,
                  input ready);
  modport sink (input valid, avg_red, avg_green, avg_blue, centre_x, centre_y, advanced,
                output ready);
endinterface

interface swpa_cfg_if;
  import swpa_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/swpa_img_mem.sv @@
`default_nettype none
module swpa_img_mem #(
  parameter int unsigned DEPTH = swpa_pkg::DEF_MAX_WIDTH * swpa_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [swpa_pkg::PIX_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [swpa_pkg::PIX_W-1:0] rdata
);
  import swpa_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ rtl/swpa_div.sv @@
`default_nettype none
module swpa_div (
  input  logic               clk,
  input  logic               rst_n,
  input  swpa_pkg::div_req_t req,
  output swpa_pkg::div_rsp_t rsp
);
  import swpa_pkg::*;

  // quotient is known to fit CH_W bits, so only CH_W restoring steps
  localparam int unsigned SW = $clog2(CH_W);

  logic             busy_r;
  logic             done_r;
  logic [SW-1:0]    cnt_r;
  logic [CNT_W-1:0] rem_r;
  logic [CNT_W-1:0] rem_nxt;
  logic [CH_W-1:0]  low_r;
  logic [CH_W-1:0]  q_r;
  logic [CNT_W-1:0] dvs_r;
  logic [CNT_W:0]   trial;
  logic             ge;

  always_comb begin
    trial   = {rem_r, low_r[CH_W-1]};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? CNT_W'(trial - {1'b0, dvs_r}) : trial[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == SW'(CH_W - 1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + SW'(1);
        if (cnt_r == SW'(CH_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.dividend[SUM_W-1:CH_W];
      low_r <= req.dividend[CH_W-1:0];
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      low_r <= {low_r[CH_W-2:0], 1'b0};
      q_r   <= {q_r[CH_W-2:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule
`default_nettype wire

@@ rtl/scanned_window_pixel_average_core.sv @@
`default_nettype none
// Write request: accepted in idle, no result.
// Step request: reads the n pixels of the clipped window (n = 1 to 64516), one memory
// read a cycle, then a shared divider averages each colour channel in turn. One request
// in flight; a held result stalls the next.
// Synchronous active-low reset clears scan position and step count and restores the
// registers to their defaults; the image memory holds garbage until written.
module scanned_window_pixel_average_core #(
  parameter int unsigned MAX_WIDTH  = swpa_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = swpa_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  swpa_in_if.sink     in_req,
  swpa_out_if.source  out_rsp,
  swpa_cfg_if.sink    cfg_req
);
  import swpa_pkg::*;

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned XW    = $clog2(MAX_WIDTH);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT);
  localparam int unsigned WXW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WYW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned SXW   = WXW + 8;
  localparam int unsigned SYW   = WYW + 8;

  // configuration
  logic [8:0]       img_w_r;
  logic [8:0]       img_h_r;
  logic [7:0]       win_r;
  logic [1:0]       dir_r;
  logic [CNT_W-1:0] spp_r;

  logic [WXW-1:0]   w_eff;
  logic [WYW-1:0]   h_eff;

  // sequencer and position
  state_t           state_r;
  state_t           state_nxt;
  logic [XW-1:0]    scan_x_r;
  logic [XW-1:0]    scan_x_nxt;
  logic [YW-1:0]    scan_y_r;
  logic [YW-1:0]    scan_y_nxt;
  logic [CNT_W-1:0] step_cnt_r;
  logic [CNT_W-1:0] step_inc;
  logic             adv;
  logic [1:0]       ch_r;
  logic             rd_vld_r;
  logic             out_vld_r;
  logic             slot_free;
  logic             in_acc;

  // window walk
  logic [1:0]       move_r;
  logic [XW-1:0]    x_last_r;
  logic [YW-1:0]    y0_r;
  logic [YW-1:0]    y_last_r;
  logic [XW-1:0]    i_r;
  logic [YW-1:0]    j_r;
  logic [SXW-1:0]   sx;
  logic [SXW-1:0]   hx;
  logic [SXW-1:0]   x0_c;
  logic [SXW-1:0]   x1_c;
  logic [SYW-1:0]   sy;
  logic [SYW-1:0]   hy;
  logic [SYW-1:0]   y0_c;
  logic [SYW-1:0]   y1_c;
  logic             empty_c;

  // accumulation
  logic [SUM_W-1:0] sum_r_r;
  logic [SUM_W-1:0] sum_g_r;
  logic [SUM_W-1:0] sum_b_r;
  logic [CNT_W-1:0] n_r;
  logic [CH_W-1:0]  q_red_r;
  logic [CH_W-1:0]  q_green_r;
  logic [CH_W-1:0]  q_blue_r;

  // result register
  logic [CH_W-1:0]  o_red_r;
  logic [CH_W-1:0]  o_green_r;
  logic [CH_W-1:0]  o_blue_r;
  logic [7:0]       o_cx_r;
  logic [7:0]       o_cy_r;
  logic             o_adv_r;

  // memory
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [PIX_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [PIX_W-1:0] mem_rdata;

  div_req_t         div_req;
  div_rsp_t         div_rsp;

  // ---------------------------------------------------------------------------
  assign cfg_req.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= 9'd256;
      img_h_r <= 9'd256;
      win_r   <= 8'd1;
      dir_r   <= DIR_ROW;
      spp_r   <= CNT_W'(1);
    end else if (cfg_req.valid && cfg_req.ready) begin
      case (cfg_reg_t'(cfg_req.index))
        REG_IMAGE_WIDTH:       img_w_r <= cfg_req.data[8:0];
        REG_IMAGE_HEIGHT:      img_h_r <= cfg_req.data[8:0];
        REG_WINDOW_SIZE:       win_r   <= cfg_req.data[7:0];
        REG_SCAN_DIRECTION:    dir_r   <= cfg_req.data[1:0];
        REG_SAMPLES_PER_PIXEL: spp_r   <= cfg_req.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (img_w_r == 9'd0) begin
      w_eff = WXW'(1);
    end else if (32'(img_w_r) > MAX_WIDTH) begin
      w_eff = WXW'(MAX_WIDTH);
    end else begin
      w_eff = WXW'(img_w_r);
    end
    if (img_h_r == 9'd0) begin
      h_eff = WYW'(1);
    end else if (32'(img_h_r) > MAX_HEIGHT) begin
      h_eff = WYW'(MAX_HEIGHT);
    end else begin
      h_eff = WYW'(img_h_r);
    end
  end

  // ---------------------------------------------------------------------------
  // window bounds, half-open; side 0 or 1 reads the centre pixel alone
  always_comb begin
    sx = SXW'(scan_x_r);
    hx = SXW'(win_r >> 1);
    sy = SYW'(scan_y_r);
    hy = SYW'(win_r >> 1);
    if (win_r <= 8'd1) begin
      x0_c = sx;
      x1_c = sx + SXW'(1);
      y0_c = sy;
      y1_c = sy + SYW'(1);
    end else begin
      x0_c = (sx > hx) ? sx - hx : '0;
      x1_c = (sx + hx < SXW'(w_eff)) ? sx + hx : SXW'(w_eff);
      y0_c = (sy > hy) ? sy - hy : '0;
      y1_c = (sy + hy < SYW'(h_eff)) ? sy + hy : SYW'(h_eff);
    end
    empty_c = (x0_c >= x1_c) || (y0_c >= y1_c);
  end

  // ---------------------------------------------------------------------------
  // position advance
  always_comb begin
    step_inc   = step_cnt_r + CNT_W'(1);
    adv        = (step_inc == spp_r);
    scan_x_nxt = scan_x_r;
    scan_y_nxt = scan_y_r;
    case (scan_dir_t'(dir_r))
      DIR_ROW: begin
        if (WXW'(scan_x_r) + WXW'(1) >= w_eff) begin
          scan_x_nxt = '0;
          if (WYW'(scan_y_r) + WYW'(1) >= h_eff) begin
            scan_y_nxt = '0;
          end else begin
            scan_y_nxt = scan_y_r + YW'(1);
          end
        end else begin
          scan_x_nxt = scan_x_r + XW'(1);
        end
      end
      DIR_COL: begin
        if (WYW'(scan_y_r) + WYW'(1) >= h_eff) begin
          scan_y_nxt = '0;
          if (WXW'(scan_x_r) + WXW'(1) >= w_eff) begin
            scan_x_nxt = '0;
          end else begin
            scan_x_nxt = scan_x_r + XW'(1);
          end
        end else begin
          scan_y_nxt = scan_y_r + YW'(1);
        end
      end
      DIR_RANDOM: begin
        case (move_t'(move_r))
          MOVE_RIGHT: begin
            if (WXW'(scan_x_r) + WXW'(1) < w_eff) scan_x_nxt = scan_x_r + XW'(1);
          end
          MOVE_DOWN: begin
            if (WYW'(scan_y_r) + WYW'(1) < h_eff) scan_y_nxt = scan_y_r + YW'(1);
          end
          MOVE_LEFT: begin
            if (scan_x_r > XW'(1)) scan_x_nxt = scan_x_r - XW'(1);
          end
          MOVE_UP: begin
            if (scan_y_r > YW'(1)) scan_y_nxt = scan_y_r - YW'(1);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  assign in_req.ready = (state_r == ST_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;
  assign slot_free    = !out_vld_r || out_rsp.ready;

  always_comb begin
    state_nxt        = state_r;
    div_req.start    = 1'b0;
    div_req.divisor  = n_r;
    case (ch_r)
      2'd0:    div_req.dividend = sum_r_r;
      2'd1:    div_req.dividend = sum_g_r;
      default: div_req.dividend = sum_b_r;
    endcase
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_req.mode == MODE_STEP) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        state_nxt = empty_c ? ST_DIV_GO : ST_READ;
      end
      ST_READ: begin
        if (j_r == y_last_r && i_r == x_last_r) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        if (n_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) state_nxt = (ch_r == 2'd2) ? ST_FIN : ST_DIV_GO;
      end
      ST_FIN: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      scan_x_r   <= '0;
      scan_y_r   <= '0;
      step_cnt_r <= '0;
      ch_r       <= '0;
      rd_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == ST_READ);
      if (state_r == ST_SETUP) begin
        ch_r <= '0;
      end else if (state_r == ST_DIV_WAIT && div_rsp.done) begin
        ch_r <= ch_r + 2'd1;
      end
      if (state_r == ST_FIN && slot_free) begin
        out_vld_r <= 1'b1;
        if (adv) begin
          step_cnt_r <= '0;
          scan_x_r   <= scan_x_nxt;
          scan_y_r   <= scan_y_nxt;
        end else begin
          step_cnt_r <= step_inc;
        end
      end else if (out_rsp.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      move_r <= in_req.random_move;
    end
    if (state_r == ST_SETUP) begin
      x_last_r <= XW'(x1_c - SXW'(1));
      y0_r     <= YW'(y0_c);
      y_last_r <= YW'(y1_c - SYW'(1));
      i_r      <= XW'(x0_c);
      j_r      <= YW'(y0_c);
    end else if (state_r == ST_READ) begin
      if (j_r == y_last_r) begin
        j_r <= y0_r;
        i_r <= i_r + XW'(1);
      end else begin
        j_r <= j_r + YW'(1);
      end
    end
    if (state_r == ST_SETUP) begin
      sum_r_r <= '0;
      sum_g_r <= '0;
      sum_b_r <= '0;
      n_r     <= '0;
    end else if (rd_vld_r) begin
      sum_r_r <= sum_r_r + SUM_W'(mem_rdata[23:16]);
      sum_g_r <= sum_g_r + SUM_W'(mem_rdata[15:8]);
      sum_b_r <= sum_b_r + SUM_W'(mem_rdata[7:0]);
      n_r     <= n_r + CNT_W'(1);
    end
    if (state_r == ST_DIV_GO && n_r == '0) begin
      q_red_r   <= '0;
      q_green_r <= '0;
      q_blue_r  <= '0;
    end else if (state_r == ST_DIV_WAIT && div_rsp.done) begin
      case (ch_r)
        2'd0:    q_red_r   <= div_rsp.quotient;
        2'd1:    q_green_r <= div_rsp.quotient;
        default: q_blue_r  <= div_rsp.quotient;
      endcase
    end
    if (state_r == ST_FIN && slot_free) begin
      o_red_r   <= q_red_r;
      o_green_r <= q_green_r;
      o_blue_r  <= q_blue_r;
      o_cx_r    <= 8'(scan_x_r);
      o_cy_r    <= 8'(scan_y_r);
      o_adv_r   <= adv;
    end
  end

  assign out_rsp.valid     = out_vld_r;
  assign out_rsp.avg_red   = o_red_r;
  assign out_rsp.avg_green = o_green_r;
  assign out_rsp.avg_blue  = o_blue_r;
  assign out_rsp.centre_x  = o_cx_r;
  assign out_rsp.centre_y  = o_cy_r;
  assign out_rsp.advanced  = o_adv_r;

  // ---------------------------------------------------------------------------
  assign mem_we    = in_acc && (in_req.mode == MODE_WRITE) &&
                     (32'(in_req.write_x) < MAX_WIDTH) && (32'(in_req.write_y) < MAX_HEIGHT);
  assign mem_waddr = AW'(32'(in_req.write_y) * MAX_WIDTH + 32'(in_req.write_x));
  assign mem_wdata = {in_req.write_red, in_req.write_green, in_req.write_blue};
  assign mem_raddr = AW'(32'(j_r) * MAX_WIDTH + 32'(i_r));

  swpa_img_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_img_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (state_r == ST_READ),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  swpa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule
`default_nettype wire
